### rtl/thsr_pkg.sv
// ----------------------------------------------------------------------------
// thsr_pkg
// Shared constants, result codes and the queue word of the triangle rasterizer.
// ----------------------------------------------------------------------------
package thsr_pkg;

  localparam int MaxDim     = 4096;
  localparam int CoordW     = $clog2(MaxDim);
  localparam int VertW      = 13;
  localparam int DimW       = 13;
  localparam int ColorW     = 32;
  localparam int QueueDepth = 2;

  localparam logic [DimW-1:0] DimReset = DimW'(1024);

  // register indexes of the configuration port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // input operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_STARTED = 2'd0,
    ST_NOTHING = 2'd1,
    ST_PIXEL   = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  // word passed from the front part to the back part
  typedef struct packed {
    status_t                  kind;
    logic [CoordW-1:0]        px;
    logic [CoordW-1:0]        py;
    logic                     last;
    logic [ColorW-1:0]        color;
    logic signed [VertW-1:0]  ax;
    logic signed [VertW-1:0]  ay;
    logic signed [VertW-1:0]  bx;
    logic signed [VertW-1:0]  by;
    logic signed [VertW-1:0]  cx;
    logic signed [VertW-1:0]  cy;
  } q_word_t;

endpackage

### rtl/thsr_front.sv
// ----------------------------------------------------------------------------
// thsr_front
// Accepts items, clips the bounding box and walks the pixel cursor.
// ----------------------------------------------------------------------------
module thsr_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [thsr_pkg::DimW-1:0]         cfg_data,
  input  logic                              push,
  input  logic                              q_full,
  input  logic                              in_op,
  input  logic signed [thsr_pkg::VertW-1:0] in_ax,
  input  logic signed [thsr_pkg::VertW-1:0] in_ay,
  input  logic signed [thsr_pkg::VertW-1:0] in_bx,
  input  logic signed [thsr_pkg::VertW-1:0] in_by_coord,
  input  logic signed [thsr_pkg::VertW-1:0] in_cx,
  input  logic signed [thsr_pkg::VertW-1:0] in_cy,
  input  logic [thsr_pkg::ColorW-1:0]       in_fill_color,
  output logic                              q_wr,
  output thsr_pkg::q_word_t                 q_word
);

  localparam int BoxW = thsr_pkg::DimW + 1;

  logic [thsr_pkg::DimW-1:0]         width_r, height_r;
  logic                              active_r, active_nxt;
  logic [thsr_pkg::CoordW-1:0]       cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [thsr_pkg::CoordW-1:0]       minx_r, maxx_r, maxy_r;
  logic [thsr_pkg::ColorW-1:0]       color_r;
  logic signed [thsr_pkg::VertW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;

  logic                  accept, is_start, box_empty, at_end;
  logic signed [BoxW-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
  logic signed [BoxW-1:0] min_x, max_x, min_y, max_y, wlim, hlim;
  logic signed [BoxW-1:0] clip_minx, clip_maxx, clip_miny, clip_maxy;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign is_start  = (in_op == thsr_pkg::OP_START);
  assign q_wr      = accept;

  always_comb begin
    ax_e = BoxW'(in_ax);
    ay_e = BoxW'(in_ay);
    bx_e = BoxW'(in_bx);
    by_e = BoxW'(in_by_coord);
    cx_e = BoxW'(in_cx);
    cy_e = BoxW'(in_cy);
    min_x = (ax_e < bx_e) ? ax_e : bx_e;
    min_x = (min_x < cx_e) ? min_x : cx_e;
    max_x = (ax_e > bx_e) ? ax_e : bx_e;
    max_x = (max_x > cx_e) ? max_x : cx_e;
    min_y = (ay_e < by_e) ? ay_e : by_e;
    min_y = (min_y < cy_e) ? min_y : cy_e;
    max_y = (ay_e > by_e) ? ay_e : by_e;
    max_y = (max_y > cy_e) ? max_y : cy_e;
    // clamp the screen size to the largest supported, then last index
    wlim = (width_r > thsr_pkg::DimW'(thsr_pkg::MaxDim))
         ? BoxW'(thsr_pkg::MaxDim - 1) : signed'({1'b0, width_r}) - BoxW'(1);
    hlim = (height_r > thsr_pkg::DimW'(thsr_pkg::MaxDim))
         ? BoxW'(thsr_pkg::MaxDim - 1) : signed'({1'b0, height_r}) - BoxW'(1);
    clip_minx = (min_x < 0) ? '0 : min_x;
    clip_miny = (min_y < 0) ? '0 : min_y;
    clip_maxx = (max_x > wlim) ? wlim : max_x;
    clip_maxy = (max_y > hlim) ? hlim : max_y;
    box_empty = (clip_minx > clip_maxx) || (clip_miny > clip_maxy);
  end

  assign at_end = (cur_x_r >= maxx_r) && (cur_y_r >= maxy_r);

  always_comb begin
    q_word      = '0;
    active_nxt  = active_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    if (is_start) begin
      q_word.ax = in_ax;
      q_word.ay = in_ay;
      q_word.bx = in_bx;
      q_word.by = in_by_coord;
      q_word.cx = in_cx;
      q_word.cy = in_cy;
      if (box_empty) begin
        q_word.kind = thsr_pkg::ST_NOTHING;
        active_nxt  = 1'b0;
      end else begin
        q_word.kind  = thsr_pkg::ST_STARTED;
        q_word.color = in_fill_color;
        active_nxt   = 1'b1;
        cur_x_nxt    = clip_minx[thsr_pkg::CoordW-1:0];
        cur_y_nxt    = clip_miny[thsr_pkg::CoordW-1:0];
      end
    end else if (active_r) begin
      q_word.kind  = thsr_pkg::ST_PIXEL;
      q_word.px    = cur_x_r;
      q_word.py    = cur_y_r;
      q_word.last  = at_end;
      q_word.color = color_r;
      q_word.ax    = ax_r;
      q_word.ay    = ay_r;
      q_word.bx    = bx_r;
      q_word.by    = by_r;
      q_word.cx    = cx_r;
      q_word.cy    = cy_r;
      if (cur_x_r < maxx_r) begin
        cur_x_nxt = cur_x_r + 1'b1;
      end else if (cur_y_r < maxy_r) begin
        cur_x_nxt = minx_r;
        cur_y_nxt = cur_y_r + 1'b1;
      end else begin
        active_nxt = 1'b0;
      end
    end else begin
      q_word.kind = thsr_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= thsr_pkg::DimReset;
      height_r <= thsr_pkg::DimReset;
      active_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == thsr_pkg::CFG_WIDTH) begin
          width_r <= cfg_data;
        end else begin
          height_r <= cfg_data;
        end
      end
      if (accept) begin
        active_r <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      if (is_start) begin
        color_r <= in_fill_color;
        ax_r    <= in_ax;
        ay_r    <= in_ay;
        bx_r    <= in_bx;
        by_r    <= in_by_coord;
        cx_r    <= in_cx;
        cy_r    <= in_cy;
        minx_r  <= clip_minx[thsr_pkg::CoordW-1:0];
        maxx_r  <= clip_maxx[thsr_pkg::CoordW-1:0];
        maxy_r  <= clip_maxy[thsr_pkg::CoordW-1:0];
      end
    end
  end

endmodule

### rtl/thsr_fifo.sv
// ----------------------------------------------------------------------------
// thsr_fifo
// Short queue of words between the front and back parts.
// ----------------------------------------------------------------------------
module thsr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  thsr_pkg::q_word_t wr_word,
  output logic              full,
  input  logic              rd,
  output logic              valid,
  output thsr_pkg::q_word_t rd_word
);

  localparam int PtrW = (thsr_pkg::QueueDepth > 1) ? $clog2(thsr_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(thsr_pkg::QueueDepth + 1);

  thsr_pkg::q_word_t mem_r [thsr_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(thsr_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CntW'(thsr_pkg::QueueDepth));
  assign valid   = (count_r != '0);
  assign rd_word = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (rd) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (wr && !rd) begin
        count_r <= count_r + 1'b1;
      end else if (rd && !wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(thsr_pkg::QueueDepth))
    else $error("queue count beyond depth");

endmodule

### rtl/thsr_back.sv
// ----------------------------------------------------------------------------
// thsr_back
// Evaluates edge functions and area sign, and holds the result word.
// ----------------------------------------------------------------------------
module thsr_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  thsr_pkg::q_word_t                  q_word,
  output logic                               q_rd,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         out_status,
  output logic [thsr_pkg::CoordW-1:0]        out_pixel_x,
  output logic [thsr_pkg::CoordW-1:0]        out_pixel_y,
  output logic                               out_covered,
  output logic                               out_last,
  output logic [thsr_pkg::ColorW-1:0]        out_color
);

  localparam int OpW   = thsr_pkg::VertW + 2;
  localparam int ProdW = 2 * OpW;
  localparam int EdgeW = ProdW + 1;

  logic                          s1_v_r;
  thsr_pkg::status_t             s1_kind_r;
  logic [thsr_pkg::CoordW-1:0]   s1_px_r, s1_py_r;
  logic                          s1_last_r;
  logic [thsr_pkg::ColorW-1:0]   s1_color_r;
  logic signed [ProdW-1:0]       prod_r [6];
  logic signed [ProdW-1:0]       prod_nxt [6];

  logic                          area_zero_r, area_neg_r;
  logic                          out_v_r;
  thsr_pkg::status_t             out_status_r, out_status_nxt;
  logic [thsr_pkg::CoordW-1:0]   out_px_r, out_px_nxt, out_py_r, out_py_nxt;
  logic                          out_cov_r, out_cov_nxt, out_last_r, out_last_nxt;
  logic [thsr_pkg::ColorW-1:0]   out_color_r, out_color_nxt;

  logic                          out_load, s1_load;
  logic signed [OpW-1:0]         ax, ay, bx, by, cx, cy, qx, qy;
  logic signed [EdgeW-1:0]       w [3];
  logic                          all_ge, all_le, covered;

  function automatic logic signed [OpW-1:0] ext(input logic signed [thsr_pkg::VertW-1:0] v);
    return OpW'(v);
  endfunction

  assign out_load = s1_v_r && (!out_v_r || pop);
  assign s1_load  = q_valid && (!s1_v_r || out_load);
  assign q_rd     = s1_load;

  // operand select: a start evaluates edge A-B at point C, which is the area
  always_comb begin
    ax = ext(q_word.ax);
    ay = ext(q_word.ay);
    bx = ext(q_word.bx);
    by = ext(q_word.by);
    cx = ext(q_word.cx);
    cy = ext(q_word.cy);
    if (q_word.kind == thsr_pkg::ST_STARTED) begin
      qx = cx;
      qy = cy;
    end else begin
      qx = signed'(OpW'(q_word.px));
      qy = signed'(OpW'(q_word.py));
    end
    prod_nxt[0] = (cx - bx) * (qy - by);
    prod_nxt[1] = (cy - by) * (qx - bx);
    prod_nxt[2] = (ax - cx) * (qy - cy);
    prod_nxt[3] = (ay - cy) * (qx - cx);
    prod_nxt[4] = (bx - ax) * (qy - ay);
    prod_nxt[5] = (by - ay) * (qx - ax);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = EdgeW'(prod_r[2*i]) - EdgeW'(prod_r[2*i+1]);
    end
    all_ge = !w[0][EdgeW-1] && !w[1][EdgeW-1] && !w[2][EdgeW-1];
    all_le = (w[0][EdgeW-1] || (w[0] == '0)) && (w[1][EdgeW-1] || (w[1] == '0))
          && (w[2][EdgeW-1] || (w[2] == '0));
    // clockwise input: the edges flip sign instead of swapping B and C
    covered = area_neg_r ? all_le : all_ge;
  end

  always_comb begin
    out_status_nxt = thsr_pkg::ST_IDLE;
    out_px_nxt     = '0;
    out_py_nxt     = '0;
    out_cov_nxt    = 1'b0;
    out_last_nxt   = 1'b0;
    out_color_nxt  = '0;
    case (s1_kind_r)
      thsr_pkg::ST_STARTED: begin
        if (w[2] == '0) begin
          out_status_nxt = thsr_pkg::ST_NOTHING;
        end else begin
          out_status_nxt = thsr_pkg::ST_STARTED;
          out_color_nxt  = s1_color_r;
        end
      end
      thsr_pkg::ST_PIXEL: begin
        if (!area_zero_r) begin
          out_status_nxt = thsr_pkg::ST_PIXEL;
          out_px_nxt     = s1_px_r;
          out_py_nxt     = s1_py_r;
          out_cov_nxt    = covered;
          out_last_nxt   = s1_last_r;
          out_color_nxt  = s1_color_r;
        end
      end
      thsr_pkg::ST_NOTHING: out_status_nxt = thsr_pkg::ST_NOTHING;
      default:              out_status_nxt = thsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      area_zero_r <= 1'b0;
      area_neg_r  <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= 1'b1;
      end else if (out_load) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
      if (out_load && (s1_kind_r == thsr_pkg::ST_STARTED)) begin
        area_zero_r <= (w[2] == '0);
        area_neg_r  <= w[2][EdgeW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind_r  <= q_word.kind;
      s1_px_r    <= q_word.px;
      s1_py_r    <= q_word.py;
      s1_last_r  <= q_word.last;
      s1_color_r <= q_word.color;
      for (int i = 0; i < 6; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_px_r     <= out_px_nxt;
      out_py_r     <= out_py_nxt;
      out_cov_r    <= out_cov_nxt;
      out_last_r   <= out_last_nxt;
      out_color_r  <= out_color_nxt;
    end
  end

  assign empty       = !out_v_r;
  assign out_status  = out_status_r;
  assign out_pixel_x = out_px_r;
  assign out_pixel_y = out_py_r;
  assign out_covered = out_cov_r;
  assign out_last    = out_last_r;
  assign out_color   = out_color_r;

  a_load_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> s1_v_r)
    else $error("result loaded from an empty stage");

  a_nonpixel_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_status_r != thsr_pkg::ST_PIXEL))
      |-> (out_px_r == '0) && (out_py_r == '0) && !out_cov_r && !out_last_r)
    else $error("pixel fields set on a non-pixel result");

  a_color_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && ((out_status_r == thsr_pkg::ST_NOTHING) ||
                 (out_status_r == thsr_pkg::ST_IDLE))) |-> (out_color_r == '0))
    else $error("color set on an empty result");

endmodule

### rtl/triangle_half_space_raster_top.sv
// ----------------------------------------------------------------------------
// triangle_half_space_raster_top
// Half-space triangle rasterizer: one start item, then one pixel per step item.
// ----------------------------------------------------------------------------
// Takes one item per clock while the queue is not full and gives one result
// per item, in order. A result passes through the queue, the multiplier stage
// and the result register before it shows on the out_ ports, where it waits
// for pop. The pixel cursor walk in the front part updates only on an accepted
// item. A start loads vertices A, B, C and a color, clips the
// bounding box to the screen and reports started or nothing to draw (zero
// area or empty box). Each step then visits the next box pixel in row-major
// order and reports whether it lies on or inside every triangle edge; a step with
// no triangle loaded reports an idle step. Clockwise input is handled by
// flipping the edge signs. Screen size registers: index 0 width, index 1
// height, both reset to 1024; write them only while the block is idle.
// ----------------------------------------------------------------------------
module triangle_half_space_raster_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [thsr_pkg::DimW-1:0]         cfg_data,
  // input queue side
  input  logic                              push,
  output logic                              full,
  input  logic                              in_op,
  input  logic signed [thsr_pkg::VertW-1:0] in_ax,
  input  logic signed [thsr_pkg::VertW-1:0] in_ay,
  input  logic signed [thsr_pkg::VertW-1:0] in_bx,
  input  logic signed [thsr_pkg::VertW-1:0] in_by_coord,
  input  logic signed [thsr_pkg::VertW-1:0] in_cx,
  input  logic signed [thsr_pkg::VertW-1:0] in_cy,
  input  logic [thsr_pkg::ColorW-1:0]       in_fill_color,
  // result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        out_status,
  output logic [thsr_pkg::CoordW-1:0]       out_pixel_x,
  output logic [thsr_pkg::CoordW-1:0]       out_pixel_y,
  output logic                              out_covered,
  output logic                              out_last,
  output logic [thsr_pkg::ColorW-1:0]       out_color
);

  // words from the front part toward the back part
  logic              q_wr, q_rd, q_valid;
  thsr_pkg::q_word_t q_wr_word, q_rd_word;

  // Classify the item, clip the box and advance the cursor.
  thsr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .q_full        (full),
    .in_op         (in_op),
    .in_ax         (in_ax),
    .in_ay         (in_ay),
    .in_bx         (in_bx),
    .in_by_coord   (in_by_coord),
    .in_cx         (in_cx),
    .in_cy         (in_cy),
    .in_fill_color (in_fill_color),
    .q_wr          (q_wr),
    .q_word        (q_wr_word)
  );

  // Hold words while the back part stalls on a full result register.
  thsr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_word (q_wr_word),
    .full    (full),
    .rd      (q_rd),
    .valid   (q_valid),
    .rd_word (q_rd_word)
  );

  // Evaluate the edge functions and drive the result register.
  thsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_word      (q_rd_word),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_status  (out_status),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_covered (out_covered),
    .out_last    (out_last),
    .out_color   (out_color)
  );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Triangle half-space rasterizer testbench
// Drives start and step words through the push/full queue and drains results
// through empty/pop, with random gaps on both sides. A scoreboard class keeps
// its own copy of the rasterizer state and screen registers, predicts one
// result word per accepted input word, and checks results in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 50;

  // one input word as the sender sees it
  typedef struct {
    logic                              op;
    logic signed [thsr_pkg::VertW-1:0] ax;
    logic signed [thsr_pkg::VertW-1:0] ay;
    logic signed [thsr_pkg::VertW-1:0] bx;
    logic signed [thsr_pkg::VertW-1:0] byc;
    logic signed [thsr_pkg::VertW-1:0] cx;
    logic signed [thsr_pkg::VertW-1:0] cy;
    logic [thsr_pkg::ColorW-1:0]       color;
  } tri_item_t;

  // one result word
  typedef struct {
    thsr_pkg::status_t           status;
    logic [thsr_pkg::CoordW-1:0] px;
    logic [thsr_pkg::CoordW-1:0] py;
    logic                        covered;
    logic                        last;
    logic [thsr_pkg::ColorW-1:0] color;
  } pixel_word_t;

  // Scoreboard: tracks triangle, box and cursor, and queues expected words.
  class raster_tracker;
    logic [thsr_pkg::DimW-1:0]   width_reg;
    logic [thsr_pkg::DimW-1:0]   height_reg;
    int                          vx[3];
    int                          vy[3];
    int                          min_col;
    int                          max_col;
    int                          max_row;
    int                          cur_x;
    int                          cur_y;
    bit                          busy;
    logic [thsr_pkg::ColorW-1:0] held;
    pixel_word_t                 due_results[$];
    int                          errors;
    int                          checked;

    function new();
      width_reg  = thsr_pkg::DimReset;
      height_reg = thsr_pkg::DimReset;
      foreach (vx[k]) begin
        vx[k] = 0;
        vy[k] = 0;
      end
      min_col = 0;
      max_col = 0;
      max_row = 0;
      cur_x   = 0;
      cur_y   = 0;
      busy    = 0;
      held    = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic idx, logic [thsr_pkg::DimW-1:0] val);
      if (idx == thsr_pkg::CFG_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    // signed area of (p1 - p0) x (p2 - p0)
    function longint orient(longint x0, longint y0, longint x1, longint y1,
                            longint x2, longint y2);
      return (x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0);
    endfunction

    // steps still needed to walk the rest of the box
    function int pixels_left();
      if (!busy) return 0;
      return (max_row - cur_y) * (max_col - min_col + 1) + (max_col - cur_x) + 1;
    endfunction

    function void accept_item(tri_item_t it);
      pixel_word_t r;
      longint      area;
      longint      w0;
      longint      w1;
      longint      w2;
      int          wlim;
      int          hlim;
      int          lo_x;
      int          hi_x;
      int          lo_y;
      int          hi_y;
      int          t;
      r.status  = thsr_pkg::ST_IDLE;
      r.px      = '0;
      r.py      = '0;
      r.covered = 1'b0;
      r.last    = 1'b0;
      r.color   = '0;
      if (it.op == thsr_pkg::OP_START) begin
        vx[0] = it.ax;
        vy[0] = it.ay;
        vx[1] = it.bx;
        vy[1] = it.byc;
        vx[2] = it.cx;
        vy[2] = it.cy;
        held  = it.color;
        busy  = 0;
        area  = orient(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
        // clockwise: swap B and C so the stored area is never negative
        if (area < 0) begin
          t = vx[1]; vx[1] = vx[2]; vx[2] = t;
          t = vy[1]; vy[1] = vy[2]; vy[2] = t;
        end
        wlim = ((width_reg < thsr_pkg::MaxDim) ? int'(width_reg) : thsr_pkg::MaxDim) - 1;
        hlim = ((height_reg < thsr_pkg::MaxDim) ? int'(height_reg) : thsr_pkg::MaxDim) - 1;
        lo_x = vx[0]; hi_x = vx[0];
        lo_y = vy[0]; hi_y = vy[0];
        for (int k = 1; k < 3; k++) begin
          if (vx[k] < lo_x) lo_x = vx[k];
          if (vx[k] > hi_x) hi_x = vx[k];
          if (vy[k] < lo_y) lo_y = vy[k];
          if (vy[k] > hi_y) hi_y = vy[k];
        end
        if (lo_x < 0) lo_x = 0;
        if (lo_y < 0) lo_y = 0;
        if (hi_x > wlim) hi_x = wlim;
        if (hi_y > hlim) hi_y = hlim;
        if (area == 0 || lo_x > hi_x || lo_y > hi_y) begin
          r.status = thsr_pkg::ST_NOTHING;
        end else begin
          min_col  = lo_x;
          max_col  = hi_x;
          max_row  = hi_y;
          cur_x    = lo_x;
          cur_y    = lo_y;
          busy     = 1;
          r.status = thsr_pkg::ST_STARTED;
          r.color  = held;
        end
      end else if (busy) begin
        w0 = orient(vx[1], vy[1], vx[2], vy[2], cur_x, cur_y);
        w1 = orient(vx[2], vy[2], vx[0], vy[0], cur_x, cur_y);
        w2 = orient(vx[0], vy[0], vx[1], vy[1], cur_x, cur_y);
        r.status  = thsr_pkg::ST_PIXEL;
        r.px      = thsr_pkg::CoordW'(cur_x);
        r.py      = thsr_pkg::CoordW'(cur_y);
        r.covered = (w0 >= 0 && w1 >= 0 && w2 >= 0);
        r.color   = held;
        if (cur_x < max_col) begin
          cur_x++;
        end else if (cur_y < max_row) begin
          cur_x = min_col;
          cur_y++;
        end else begin
          r.last = 1'b1;
          busy   = 0;
        end
      end
      due_results = {due_results, r};
    endfunction

    function void check_word(pixel_word_t got);
      pixel_word_t want;
      checked++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: no result expected, got status %0d x %0d y %0d",
                   checked, got.status, got.px, got.py);
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status || got.px !== want.px || got.py !== want.py ||
            got.covered !== want.covered || got.last !== want.last ||
            got.color !== want.color) begin
          errors++;
          if (errors <= 10) begin
            $display("result %0d: expected st %0d x %0d y %0d cov %b last %b col %h",
                     checked, want.status, want.px, want.py, want.covered, want.last,
                     want.color);
            $display("result %0d:      got st %0d x %0d y %0d cov %b last %b col %h",
                     checked, got.status, got.px, got.py, got.covered, got.last,
                     got.color);
          end
        end
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic                              cfg_index = thsr_pkg::CFG_WIDTH;
  logic [thsr_pkg::DimW-1:0]         cfg_data = '0;
  logic                              push = 1'b0;
  logic                              full;
  logic                              in_op = thsr_pkg::OP_STEP;
  logic signed [thsr_pkg::VertW-1:0] in_ax = '0;
  logic signed [thsr_pkg::VertW-1:0] in_ay = '0;
  logic signed [thsr_pkg::VertW-1:0] in_bx = '0;
  logic signed [thsr_pkg::VertW-1:0] in_by_coord = '0;
  logic signed [thsr_pkg::VertW-1:0] in_cx = '0;
  logic signed [thsr_pkg::VertW-1:0] in_cy = '0;
  logic [thsr_pkg::ColorW-1:0]       in_fill_color = '0;
  logic                              empty;
  logic                              pop = 1'b0;
  logic [1:0]                        out_status;
  logic [thsr_pkg::CoordW-1:0]       out_pixel_x;
  logic [thsr_pkg::CoordW-1:0]       out_pixel_y;
  logic                              out_covered;
  logic                              out_last;
  logic [thsr_pkg::ColorW-1:0]       out_color;

  raster_tracker tracker = new();

  int items_sent = 0;
  int cycle_count = 0;
  int pop_hold = 0;
  bit gaps_on = 1'b0;
  bit pop_gaps_on = 1'b0;

  triangle_half_space_raster_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_op        (in_op),
    .in_ax        (in_ax),
    .in_ay        (in_ay),
    .in_bx        (in_bx),
    .in_by_coord  (in_by_coord),
    .in_cx        (in_cx),
    .in_cy        (in_cy),
    .in_fill_color(in_fill_color),
    .empty        (empty),
    .pop          (pop),
    .out_status   (out_status),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_covered  (out_covered),
    .out_last     (out_last),
    .out_color    (out_color)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop: no correct run gets anywhere near this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side: check the word taken at this edge, then pick next pop.
  always @(posedge clk) begin
    pixel_word_t got;
    if (rst_n && pop && !empty) begin
      got.status  = thsr_pkg::status_t'(out_status);
      got.px      = out_pixel_x;
      got.py      = out_pixel_y;
      got.covered = out_covered;
      got.last    = out_last;
      got.color   = out_color;
      tracker.check_word(got);
    end
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (pop_gaps_on && $urandom_range(0, 3) == 0) pop_hold <= pick_gap();
    end
  end

  function automatic tri_item_t make_start(int ax, int ay, int bx, int b_y, int cx, int cy,
                                           logic [thsr_pkg::ColorW-1:0] color);
    tri_item_t it;
    it.op    = thsr_pkg::OP_START;
    it.ax    = thsr_pkg::VertW'(ax);
    it.ay    = thsr_pkg::VertW'(ay);
    it.bx    = thsr_pkg::VertW'(bx);
    it.byc   = thsr_pkg::VertW'(b_y);
    it.cx    = thsr_pkg::VertW'(cx);
    it.cy    = thsr_pkg::VertW'(cy);
    it.color = color;
    return it;
  endfunction

  // Step word: vertex and color fields are don't-care, so fill them with noise.
  function automatic tri_item_t step_item();
    tri_item_t it;
    it.op    = thsr_pkg::OP_STEP;
    it.ax    = thsr_pkg::VertW'($urandom);
    it.ay    = thsr_pkg::VertW'($urandom);
    it.bx    = thsr_pkg::VertW'($urandom);
    it.byc   = thsr_pkg::VertW'($urandom);
    it.cx    = thsr_pkg::VertW'($urandom);
    it.cy    = thsr_pkg::VertW'($urandom);
    it.color = $urandom;
    return it;
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  // Present one word, hold it until the queue takes it, then note it.
  // push stays high on return so back-to-back words need no extra edge.
  task automatic send_item(tri_item_t it);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_op         <= it.op;
    in_ax         <= it.ax;
    in_ay         <= it.ay;
    in_bx         <= it.bx;
    in_by_coord   <= it.byc;
    in_cx         <= it.cx;
    in_cy         <= it.cy;
    in_fill_color <= it.color;
    do @(posedge clk); while (full);
    tracker.accept_item(it);
    items_sent++;
  endtask

  // Leaves cfg_valid high; the caller drops it once after the last write.
  task automatic write_config(logic idx, logic [thsr_pkg::DimW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
  endtask

  // Hold off the sender until every expected word has come back.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (tracker.due_results.size() != 0);
  endtask

  task automatic directed_items();
    // step with nothing loaded
    send_item(step_item());
    // collinear vertices: zero area
    send_item(make_start(0, 0, 5, 5, 10, 10, 32'h0000_0000));
    // clockwise input, walk the whole 3x3 box, then one step past the end
    send_item(make_start(0, 0, 0, 2, 2, 0, 32'hA5A5_5A5A));
    repeat (10) send_item(step_item());
    // extreme vertices, then abandon with a new start
    send_item(make_start(-4096, -4096, 4095, -4096, -4096, 4095, 32'hFFFF_FFFF));
    repeat (2) send_item(step_item());
    // box entirely left of and above the screen
    send_item(make_start(-4096, -10, -5, -4096, -1, -1, 32'h1234_5678));
    send_item(step_item());
    // box entirely right of the screen
    send_item(make_start(1024, 0, 2000, 5, 1500, 900, 32'h0F0F_0F0F));
    // counterclockwise triangle in the far corner of the screen
    send_item(make_start(1023, 1023, 1020, 1023, 1023, 1020, 32'h8000_0001));
    repeat (3) send_item(step_item());
    // degenerate point at the top of the coordinate range
    send_item(make_start(4095, 4095, 4095, 4095, 4095, 4095, 32'h7FFF_FFFE));
  endtask

  // Mostly well-formed triangles walked to the end, plus abandoned walks,
  // wild full-range starts and stray steps.
  task automatic random_phase(int target);
    int first;
    int kind;
    int n;
    int ox;
    int oy;
    int spread;
    int lim_x;
    int lim_y;
    first = items_sent;
    while (items_sent - first < target) begin
      kind    = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (kind < 80) begin
        lim_x  = (tracker.width_reg < thsr_pkg::MaxDim) ? int'(tracker.width_reg)
                                                        : thsr_pkg::MaxDim;
        lim_y  = (tracker.height_reg < thsr_pkg::MaxDim) ? int'(tracker.height_reg)
                                                         : thsr_pkg::MaxDim;
        spread = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 5);
        ox     = int'($urandom_range(0, lim_x + 7)) - 8;
        oy     = int'($urandom_range(0, lim_y + 7)) - 8;
        send_item(make_start(clamp_coord(ox + int'($urandom_range(0, spread))),
                             clamp_coord(oy + int'($urandom_range(0, spread))),
                             clamp_coord(ox + int'($urandom_range(0, spread))),
                             clamp_coord(oy + int'($urandom_range(0, spread))),
                             clamp_coord(ox + int'($urandom_range(0, spread))),
                             clamp_coord(oy + int'($urandom_range(0, spread))),
                             $urandom));
        n = tracker.pixels_left();
        // cut some walks short; run the rest to the end and a little past
        if (kind >= 68) n = $urandom_range(0, n);
        else n = n + $urandom_range(0, 2);
        repeat (n) send_item(step_item());
      end else if (kind < 90) begin
        send_item(make_start($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom));
        repeat ($urandom_range(0, 5)) send_item(step_item());
      end else begin
        repeat ($urandom_range(1, 3)) send_item(step_item());
      end
    end
  endtask

  initial begin
    int cfg_w[10];
    int cfg_h[10];
    // zero and oversized registers, single pixel, full size, thin screens
    cfg_w = '{8191, 0, 64, 1, 4096, 5000, 33, 4095, 0, 0};
    cfg_h = '{8191, 37, 0, 1, 4096, 23, 4095, 2, 0, 0};
    cfg_w[8] = $urandom_range(1, 300);
    cfg_h[8] = $urandom_range(1, 300);
    cfg_w[9] = $urandom_range(1, 4096);
    cfg_h[9] = $urandom_range(1, 4096);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // run the directed words on the reset screen size, no idling
    directed_items();
    drain();

    for (int p = 0; p < 10; p++) begin
      write_config(thsr_pkg::CFG_WIDTH, thsr_pkg::DimW'(cfg_w[p]));
      write_config(thsr_pkg::CFG_HEIGHT, thsr_pkg::DimW'(cfg_h[p]));
      cfg_valid   <= 1'b0;
      pop_gaps_on = (p % 3 != 0);
      random_phase(PhaseItems);
      drain();
    end

    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
